// ----- src/ffba_pkg.sv -----
// Shared constants and types of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

  localparam int unsigned SlotW  = 4;   // slot and block_index field width
  localparam int unsigned SizeW  = 16;  // size and leftover field width
  localparam int unsigned FragW  = 20;  // total_fragmentation field width
  localparam int unsigned CountW = 5;   // block_count register width

  localparam logic [FragW-1:0] FragMax = {FragW{1'b1}};

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  // Control part of the search token that travels along the cell row.
  typedef struct packed {
    logic active;  // a request occupies this stage
    logic found;   // an earlier cell already granted it
  } tok_t;

endpackage
`default_nettype wire

// ----- src/ffba_if.sv -----
// Channel interfaces of the first-fit block allocator.
`default_nettype none

interface ffba_req_if
  import ffba_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             op;
  logic [SlotW-1:0] slot;
  logic [SizeW-1:0] size;

  modport source (output valid, output op, output slot, output size, input ready);
  modport sink   (input valid, input op, input slot, input size, output ready);
endinterface

interface ffba_rsp_if
  import ffba_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             granted;
  logic [SlotW-1:0] block_index;
  logic [SizeW-1:0] leftover;
  logic [FragW-1:0] total_fragmentation;

  modport source (output valid, output granted, output block_index, output leftover,
                  output total_fragmentation, input ready);
  modport sink   (input valid, input granted, input block_index, input leftover,
                  input total_fragmentation, output ready);
endinterface

interface ffba_cfg_if
  import ffba_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/ffba_cell.sv -----
// One slot of the allocator: block size, used mark and one token stage.
`default_nettype none
module ffba_cell
  import ffba_pkg::*;
#(
  parameter int unsigned SIZE_BITS = 16,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned IDX       = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // load port, broadcast to every cell
  input  wire logic                 load_i,
  input  wire logic [SlotW-1:0]     load_slot_i,
  input  wire logic [SIZE_BITS-1:0] load_size_i,
  input  wire logic [CountW-1:0]    block_count_i,
  // token from the left neighbor
  input  wire tok_t                 tok_i,
  input  wire logic [SIZE_BITS-1:0] req_i,
  input  wire logic [IDX_W-1:0]     idx_i,
  input  wire logic [SIZE_BITS-1:0] left_i,
  // token to the right neighbor
  output tok_t                      tok_o,
  output logic [SIZE_BITS-1:0]      req_o,
  output logic [IDX_W-1:0]          idx_o,
  output logic [SIZE_BITS-1:0]      left_o
);

  logic [SIZE_BITS-1:0] size_q;
  logic                 used_q;
  tok_t                 tok_q;
  logic [SIZE_BITS-1:0] req_q;
  logic [IDX_W-1:0]     idx_q;
  logic [SIZE_BITS-1:0] left_q;

  logic load_hit;
  logic in_range;
  logic grant;

  assign load_hit = load_i && (32'(load_slot_i) == 32'(IDX));
  assign in_range = 32'(block_count_i) > 32'(IDX);
  assign grant    = tok_i.active && !tok_i.found && !used_q && in_range && (size_q >= req_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      if (load_hit) begin
        used_q <= 1'b0;
      end else if (grant) begin
        used_q <= 1'b1;
      end
      tok_q.active <= tok_i.active;
      tok_q.found  <= tok_i.found | grant;
    end
  end

  // Payload: size store and token data, no reset.
  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      size_q <= load_size_i;
    end
    req_q  <= req_i;
    idx_q  <= grant ? IDX_W'(IDX) : idx_i;
    left_q <= grant ? size_q - req_i : left_i;
  end

  assign tok_o  = tok_q;
  assign req_o  = req_q;
  assign idx_o  = idx_q;
  assign left_o = left_q;

endmodule
`default_nettype wire

// ----- src/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator: a row of slot cells and the control.
//
//  channel  | dir | modport | payload
//  ---------+-----+---------+-------------------------------------------------
//  in_i     | in  | sink    | op, slot, size
//  out_o    | out | source  | granted, block_index, leftover, total_fragmentation
//  cfg_i    | in  | sink    | data = block_count
//
// A load writes the named cell at its transfer and shows its result on out_o
// in the next cycle. A request enters the cell row as a token and moves one
// cell per cycle; the first free cell in range whose size fits claims it,
// and the result register takes the outcome once the token leaves the last
// cell of the row. One item is in flight at a time: in_i takes an item only
// while no search runs and the result register is empty or being drained.
// Reset marks every slot free and clears the total and block_count; block
// sizes are undefined until loaded. cfg_i is always ready.
`default_nettype none
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ffba_req_if.sink   in_i,
  ffba_rsp_if.source out_o,
  ffba_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  // Wide enough for the total plus a leftover, and for any size or index field.
  localparam int unsigned WideW = ((SIZE_BITS > FragW) ? SIZE_BITS : FragW) + IdxW + 1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e           state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [FragW-1:0] frag_q, frag_d;
  logic             out_valid_q, out_valid_d;
  logic             out_granted_q, out_granted_d;
  logic [SlotW-1:0] out_index_q, out_index_d;
  logic [SizeW-1:0] out_left_q, out_left_d;

  logic in_xfer;
  logic load_go;
  logic req_go;

  // Token chain between the cells; stage 0 is the injection point.
  tok_t                 tok   [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] req   [NUM_BLOCKS+1];
  logic [IdxW-1:0]      idx   [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] left  [NUM_BLOCKS+1];

  logic [WideW-1:0]     size_wide;
  logic [SIZE_BITS-1:0] size_cut;
  logic [WideW-1:0]     sum_wide;
  logic [WideW-1:0]     left_wide;
  logic [WideW-1:0]     idx_wide;
  tok_t                 tok_end;

  assign in_i.ready  = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign load_go     = in_xfer && (in_i.op == OP_LOAD);
  assign req_go      = in_xfer && (in_i.op == OP_REQUEST);
  assign cfg_i.ready = 1'b1;

  // Take sizes modulo 2^SIZE_BITS.
  assign size_wide = WideW'(in_i.size);
  assign size_cut  = size_wide[SIZE_BITS-1:0];

  // Inject a fresh token on a request transfer.
  assign tok[0].active = req_go;
  assign tok[0].found  = 1'b0;
  assign req[0]        = size_cut;
  assign idx[0]        = '0;
  assign left[0]       = '0;

  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    ffba_cell #(
      .SIZE_BITS(SIZE_BITS),
      .IDX_W    (IdxW),
      .IDX      (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_i       (load_go),
      .load_slot_i  (in_i.slot),
      .load_size_i  (size_cut),
      .block_count_i(count_q),
      .tok_i        (tok[g]),
      .req_i        (req[g]),
      .idx_i        (idx[g]),
      .left_i       (left[g]),
      .tok_o        (tok[g+1]),
      .req_o        (req[g+1]),
      .idx_o        (idx[g+1]),
      .left_o       (left[g+1])
    );
  end

  assign tok_end   = tok[NUM_BLOCKS];
  assign left_wide = WideW'(left[NUM_BLOCKS]);
  assign idx_wide  = WideW'(idx[NUM_BLOCKS]);
  assign sum_wide  = WideW'(frag_q) + left_wide;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    frag_d        = frag_q;
    out_valid_d   = out_valid_q;
    out_granted_d = out_granted_q;
    out_index_d   = out_index_q;
    out_left_d    = out_left_q;

    if (cfg_i.valid) begin
      count_d = cfg_i.data;
    end

    // Drop the result once the sink takes it.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (load_go) begin
          out_valid_d   = 1'b1;
          out_granted_d = 1'b0;
          out_index_d   = in_i.slot;
          out_left_d    = '0;
        end else if (req_go) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_end.active) begin
          state_d       = ST_IDLE;
          out_valid_d   = 1'b1;
          out_granted_d = tok_end.found;
          if (tok_end.found) begin
            out_index_d = idx_wide[SlotW-1:0];
            out_left_d  = left_wide[SizeW-1:0];
            frag_d      = (sum_wide > WideW'(FragMax)) ? FragMax : sum_wide[FragW-1:0];
          end else begin
            out_index_d = '0;
            out_left_d  = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      frag_q        <= '0;
      out_valid_q   <= 1'b0;
      out_granted_q <= 1'b0;
      out_index_q   <= '0;
      out_left_q    <= '0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      frag_q        <= frag_d;
      out_valid_q   <= out_valid_d;
      out_granted_q <= out_granted_d;
      out_index_q   <= out_index_d;
      out_left_q    <= out_left_d;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.granted             = out_granted_q;
  assign out_o.block_index         = out_index_q;
  assign out_o.leftover            = out_left_q;
  assign out_o.total_fragmentation = frag_q;

endmodule
`default_nettype wire
